[rtl/tsbcc_pkg.sv]
// shared types and constants for the three-stage battery charge controller
`timescale 1ns / 1ps

package tsbcc_pkg;

    // parameter defaults
    localparam int PWM_TOP_DEF          = 319;
    localparam int FILTER_FRAC_BITS_DEF = 4;

    // configuration port geometry
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [2:0] REG_ABSORB_V  = 3'd0;
    localparam logic [2:0] REG_FLOAT_V   = 3'd1;
    localparam logic [2:0] REG_RESTART_V = 3'd2;
    localparam logic [2:0] REG_MAX_V     = 3'd3;
    localparam logic [2:0] REG_BULK_I    = 3'd4;
    localparam logic [2:0] REG_MAX_I     = 3'd5;
    localparam logic [2:0] REG_LOAD_OFF  = 3'd6;
    localparam logic [2:0] REG_LOAD_ON   = 3'd7;

    // charge stage codes
    localparam logic [1:0] ST_BULK   = 2'd0;
    localparam logic [1:0] ST_ABSORB = 2'd1;
    localparam logic [1:0] ST_FLOAT  = 2'd2;
    localparam logic [1:0] ST_FAULT  = 2'd3;

    // duty control constants, 1/10000 units
    localparam int DUTY_INC   = 5;
    localparam int DUTY_MIN   = 500;
    localparam int DUTY_MAX   = 9900;
    localparam int DUTY_RESET = 3000;

    // deadbands and thresholds
    localparam int VOLT_DEADBAND_MV = 40;
    localparam int ABS_EXIT_MA      = 40;
    localparam int CUR_DEADBAND_MA  = 100;

    // configuration register set
    typedef struct packed {
        logic [15:0] absorb_voltage_mv;
        logic [15:0] float_voltage_mv;
        logic [15:0] restart_bulk_mv;
        logic [15:0] max_voltage_mv;
        logic [14:0] bulk_current_ma;
        logic [14:0] max_current_ma;
        logic [15:0] load_off_mv;
        logic [15:0] load_on_mv;
    } cfg_t;

    // control result handed to the pwm stage
    typedef struct packed {
        logic [1:0]  charge_stage;
        logic [13:0] duty_level;
        logic        load_enable;
        logic [15:0] filtered_mv;
    } ctrl_res_t;

endpackage

[rtl/tsbcc_cfg_regs.sv]
// apb configuration registers for the charge controller
`timescale 1ns / 1ps

module tsbcc_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tsbcc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [tsbcc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [tsbcc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                               pready,
    output tsbcc_pkg::cfg_t                    cfg
);
    import tsbcc_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.absorb_voltage_mv <= 16'd7300;
            cfg_reg.float_voltage_mv  <= 16'd6800;
            cfg_reg.restart_bulk_mv   <= 16'd6300;
            cfg_reg.max_voltage_mv    <= 16'd7500;
            cfg_reg.bulk_current_ma   <= 15'd200;
            cfg_reg.max_current_ma    <= 15'd400;
            cfg_reg.load_off_mv       <= 16'd5850;
            cfg_reg.load_on_mv        <= 16'd6450;
        end else if (wr_en) begin
            case (idx)
                REG_ABSORB_V:  cfg_reg.absorb_voltage_mv <= pwdata[15:0];
                REG_FLOAT_V:   cfg_reg.float_voltage_mv  <= pwdata[15:0];
                REG_RESTART_V: cfg_reg.restart_bulk_mv   <= pwdata[15:0];
                REG_MAX_V:     cfg_reg.max_voltage_mv    <= pwdata[15:0];
                REG_BULK_I:    cfg_reg.bulk_current_ma   <= pwdata[14:0];
                REG_MAX_I:     cfg_reg.max_current_ma    <= pwdata[14:0];
                REG_LOAD_OFF:  cfg_reg.load_off_mv       <= pwdata[15:0];
                REG_LOAD_ON:   cfg_reg.load_on_mv        <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // read mux
    always_comb begin
        case (idx)
            REG_ABSORB_V:  prdata = CFG_DATA_W'(cfg_reg.absorb_voltage_mv);
            REG_FLOAT_V:   prdata = CFG_DATA_W'(cfg_reg.float_voltage_mv);
            REG_RESTART_V: prdata = CFG_DATA_W'(cfg_reg.restart_bulk_mv);
            REG_MAX_V:     prdata = CFG_DATA_W'(cfg_reg.max_voltage_mv);
            REG_BULK_I:    prdata = CFG_DATA_W'(cfg_reg.bulk_current_ma);
            REG_MAX_I:     prdata = CFG_DATA_W'(cfg_reg.max_current_ma);
            REG_LOAD_OFF:  prdata = CFG_DATA_W'(cfg_reg.load_off_mv);
            REG_LOAD_ON:   prdata = CFG_DATA_W'(cfg_reg.load_on_mv);
            default:       prdata = '0;
        endcase
    end

endmodule

[rtl/tsbcc_core.sv]
// voltage filter, charge stage machine, duty stepping and load relay
`timescale 1ns / 1ps

module tsbcc_core #(
    parameter int FILTER_FRAC_BITS = tsbcc_pkg::FILTER_FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tsbcc_pkg::cfg_t       cfg,
    input  logic                  fire,
    input  logic [15:0]           voltage_mv,
    input  logic signed [15:0]    current_ma,
    output tsbcc_pkg::ctrl_res_t  res
);
    import tsbcc_pkg::*;

    localparam int AW = 16 + FILTER_FRAC_BITS;   // accumulator width
    localparam int EW = AW + 2;                  // signed compare width
    localparam int DS = AW + 4;                  // reciprocal shift for divide by ten
    localparam int MW = DS - 2;
    localparam longint unsigned DIV10_L = ((64'd1 << DS) + 64'd9) / 64'd10;
    localparam logic [MW-1:0] DIV10_M = MW'(DIV10_L);
    localparam logic signed [EW-1:0] DB_S =
        EW'(VOLT_DEADBAND_MV * (1 << FILTER_FRAC_BITS));

    logic [1:0]         stage_reg, stage_next;
    logic [13:0]        duty_reg, duty_next;
    logic [AW-1:0]      acc_reg, acc_next;
    logic               primed_reg;
    logic               load_reg, load_next;
    ctrl_res_t          res_reg;

    logic [AW-1:0]      sample;
    logic signed [AW:0] diff;
    logic [AW-1:0]      mag;
    logic [AW+MW-1:0]   prod;
    logic [AW-1:0]      quo;
    logic [AW-1:0]      acc_upd;
    logic signed [EW-1:0] v_s, tgt_lo, tgt_hi;
    logic signed [16:0] cur, bulk_i, bulk_hi, max_i;
    logic               abs_ok;
    logic [15:0]        target;
    logic signed [15:0] delta, duty_sum;

    function automatic logic signed [EW-1:0] scale(input logic [15:0] mv);
        scale = $signed(EW'(mv) << FILTER_FRAC_BITS);
    endfunction

    // exponential filter, divide by ten through a reciprocal multiply
    assign sample  = AW'(voltage_mv) << FILTER_FRAC_BITS;
    assign diff    = $signed({1'b0, sample}) - $signed({1'b0, acc_reg});
    assign mag     = diff[AW] ? AW'(-diff) : diff[AW-1:0];
    assign prod    = (AW+MW)'(mag) * (AW+MW)'(DIV10_M);
    assign quo     = AW'(prod >> DS);
    assign acc_upd = diff[AW] ? (acc_reg - quo) : (acc_reg + quo);
    assign acc_next = primed_reg ? acc_upd : sample;

    // operands for the compares
    assign v_s     = $signed(EW'(acc_next));
    assign cur     = 17'(current_ma);
    assign bulk_i  = $signed({2'b00, cfg.bulk_current_ma});
    assign max_i   = $signed({2'b00, cfg.max_current_ma});
    assign bulk_hi = bulk_i + 17'(CUR_DEADBAND_MA);
    assign abs_ok  = v_s >= scale(cfg.absorb_voltage_mv);

    // stage machine
    always_comb begin
        stage_next = stage_reg;
        if (v_s > scale(cfg.max_voltage_mv) || cur > max_i) begin
            stage_next = ST_FAULT;
        end else begin
            case (stage_reg)
                ST_BULK: begin
                    if (abs_ok) stage_next = ST_ABSORB;
                end
                ST_ABSORB: begin
                    if (cur <= 17'(ABS_EXIT_MA) && abs_ok) stage_next = ST_FLOAT;
                end
                ST_FLOAT: begin
                    if (v_s <= scale(cfg.restart_bulk_mv)) stage_next = ST_BULK;
                end
                default: begin
                    if (!abs_ok && cur < bulk_i) stage_next = ST_BULK;
                end
            endcase
        end
    end

    // duty stepping and clamp
    assign target = (stage_next == ST_ABSORB) ? cfg.absorb_voltage_mv : cfg.float_voltage_mv;
    assign tgt_lo = scale(target) - DB_S;
    assign tgt_hi = scale(target) + DB_S;

    always_comb begin
        delta = '0;
        if (stage_next == ST_BULK) begin
            if (cur < bulk_i) delta = 16'(DUTY_INC);
            else if (cur > bulk_hi) delta = -16'(DUTY_INC);
        end else begin
            if (v_s < tgt_lo) delta = 16'(DUTY_INC);
            else if (v_s > tgt_hi) delta = -16'(DUTY_INC);
        end
        duty_sum = $signed({2'b00, duty_reg}) + delta;
        if (stage_next == ST_FAULT) begin
            duty_next = '0;
        end else if (duty_sum > 16'sd9900) begin
            duty_next = 14'(DUTY_MAX);
        end else if (duty_sum < 16'sd500) begin
            duty_next = 14'(DUTY_MIN);
        end else begin
            duty_next = duty_sum[13:0];
        end
    end

    // hysteretic load relay, off wins
    always_comb begin
        load_next = load_reg;
        if (v_s <= scale(cfg.load_off_mv)) load_next = 1'b0;
        else if (v_s >= scale(cfg.load_on_mv)) load_next = 1'b1;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg  <= ST_BULK;
            duty_reg   <= 14'(DUTY_RESET);
            acc_reg    <= '0;
            primed_reg <= 1'b0;
            load_reg   <= 1'b0;
        end else if (fire) begin
            stage_reg  <= stage_next;
            duty_reg   <= duty_next;
            acc_reg    <= acc_next;
            primed_reg <= 1'b1;
            load_reg   <= load_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg.charge_stage <= stage_next;
            res_reg.duty_level   <= duty_next;
            res_reg.load_enable  <= load_next;
            res_reg.filtered_mv  <= 16'(acc_next >> FILTER_FRAC_BITS);
        end
    end

    assign res = res_reg;

`ifndef ASSERT_OFF
    // state only moves on an accepted request
    a_hold_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> ($stable(stage_reg) && $stable(duty_reg) && $stable(acc_reg)))
        else $error("control state changed without a request");

    // fault stage keeps the converter off
    a_fault_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_reg == ST_FAULT) |-> (duty_reg == 14'd0))
        else $error("duty not zero in fault");

    // outside fault the duty stays inside its clamp
    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_reg != ST_FAULT) |->
            (duty_reg >= 14'(DUTY_MIN) && duty_reg <= 14'(DUTY_MAX)))
        else $error("duty outside clamp range");
`endif

endmodule

[rtl/tsbcc_pwm.sv]
// pwm compare calculation and output register
`timescale 1ns / 1ps

module tsbcc_pwm #(
    parameter int PWM_TOP = tsbcc_pkg::PWM_TOP_DEF
) (
    input  logic                  aclk,
    input  logic                  load,
    input  tsbcc_pkg::ctrl_res_t  res_in,
    output tsbcc_pkg::ctrl_res_t  res_out,
    output logic [8:0]            pwm_compare
);
    import tsbcc_pkg::*;

    // duty*(period+1)/10000 folded into one constant multiply
    localparam int KS = 28;
    localparam longint unsigned K_L =
        (((longint'(PWM_TOP) + 64'd1) << KS) + 64'd9999) / 64'd10000;
    localparam logic [30:0] K_C = 31'(K_L);

    ctrl_res_t   res_reg;
    logic [8:0]  pwm_reg;
    logic [44:0] prod;
    logic [16:0] cmp;
    logic [16:0] capped;

    assign prod   = 45'(res_in.duty_level) * 45'(K_C);
    assign cmp    = 17'(prod >> KS);
    assign capped = (cmp > 17'(PWM_TOP)) ? 17'(PWM_TOP) : cmp;

    // output register
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
            pwm_reg <= capped[8:0];
        end
    end

    assign res_out     = res_reg;
    assign pwm_compare = pwm_reg;

endmodule

[rtl/three_stage_battery_charge_control_top.sv]
// top level of the three-stage battery charge controller
`timescale 1ns / 1ps

// Three-stage lead-acid charge controller (bulk, absorption, float, fault).
// Each request on the s_ channel carries one voltage and one current sample
// and yields exactly one result on the m_ channel. One request is accepted
// every clock cycle while m_tready stays high; a result is presented on m_
// once its request has passed the input register, the result register and the
// output register (the input register feeds the control update into the result
// register, then the pwm compare multiply into the output register). The filter,
// stage machine and duty state are updated as the result register is loaded,
// so consecutive samples never wait on each other. Thresholds are
// written over the APB port at byte address 4*index and should only be
// changed while no sample is in flight.
module three_stage_battery_charge_control_top #(
    parameter int PWM_TOP          = tsbcc_pkg::PWM_TOP_DEF,
    parameter int FILTER_FRAC_BITS = tsbcc_pkg::FILTER_FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // sample input
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [31:0]                        s_tdata,  // voltage_mv[15:0], current_ma[31:16]
    // result output
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // charge_stage[1:0], duty_level[15:2], pwm_compare[24:16], load_enable[25],
    // filtered_mv[41:26], zero fill[47:42]
    output logic [47:0]                        m_tdata,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tsbcc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [tsbcc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [tsbcc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                               pready
);
    import tsbcc_pkg::*;

    cfg_t               cfg;
    ctrl_res_t          mid_res, out_res;
    logic [8:0]         pwm_cmp;

    logic               in_v_reg, mid_v_reg, out_v_reg;
    logic [15:0]        volt_reg;
    logic signed [15:0] cur_reg;
    logic               in_rdy, mid_rdy, out_rdy;
    logic               core_fire, pwm_load;

    // pipeline flow control
    assign out_rdy   = !out_v_reg || m_tready;
    assign mid_rdy   = !mid_v_reg || out_rdy;
    assign in_rdy    = !in_v_reg || mid_rdy;
    assign core_fire = in_v_reg && mid_rdy;
    assign pwm_load  = mid_v_reg && out_rdy;
    assign s_tready  = in_rdy;
    assign m_tvalid  = out_v_reg;

    // stage valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg  <= 1'b0;
            mid_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (in_rdy)  in_v_reg  <= s_tvalid;
            if (mid_rdy) mid_v_reg <= in_v_reg;
            if (out_rdy) out_v_reg <= mid_v_reg;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (s_tvalid && in_rdy) begin
            volt_reg <= s_tdata[15:0];
            cur_reg  <= $signed(s_tdata[31:16]);
        end
    end

    tsbcc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tsbcc_core #(
        .FILTER_FRAC_BITS (FILTER_FRAC_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .fire       (core_fire),
        .voltage_mv (volt_reg),
        .current_ma (cur_reg),
        .res        (mid_res)
    );

    tsbcc_pwm #(
        .PWM_TOP (PWM_TOP)
    ) u_pwm (
        .aclk        (aclk),
        .load        (pwm_load),
        .res_in      (mid_res),
        .res_out     (out_res),
        .pwm_compare (pwm_cmp)
    );

    // result packing
    assign m_tdata = {6'b000000, out_res.filtered_mv, out_res.load_enable, pwm_cmp,
                      out_res.duty_level, out_res.charge_stage};

endmodule

[verif/tb_three_stage_battery_charge_control_top.sv]
// self-checking stream testbench for the three-stage battery charge controller
`timescale 1ns / 1ps

module tb_three_stage_battery_charge_control_top;

    import tsbcc_pkg::*;

    localparam longint FIX_ONE     = longint'(1) << FILTER_FRAC_BITS_DEF;
    localparam int     STALL_LIMIT = 2000;
    localparam int     SETTLE_CYC  = 8;

    // one expected result, fields as they travel on m_tdata
    typedef struct packed {
        logic [1:0]  stage;
        logic [13:0] duty;
        logic [8:0]  pwm;
        logic        load;
        logic [15:0] filt;
    } charge_res_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // voltage_mv[15:0], current_ma[31:16]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // charge_stage[1:0], duty_level[15:2], pwm_compare[24:16], load_enable[25],
    // filtered_mv[41:26], zero fill[47:42]
    logic [47:0] m_tdata;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // samples waiting to be sent and results still owed by the block
    logic [31:0] pending_readings[$];
    charge_res_t charge_results_due[$];

    // mirror of the controller state and thresholds
    cfg_t       thresholds;
    logic [1:0] stage_q     = ST_BULK;
    int         duty_q      = DUTY_RESET;
    longint     filt_acc    = 0;
    bit         filt_primed = 1'b0;
    bit         load_q      = 1'b0;

    int errors        = 0;
    int idle_cycles   = 0;
    int send_gap      = 0;
    int recv_gap      = 0;
    bit send_idle_on  = 1'b1;
    bit recv_idle_on  = 1'b1;

    three_stage_battery_charge_control_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock, 2 ns period
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic longint mv_fix(input longint mv);
        return mv * FIX_ONE;
    endfunction

    // one control step: filter, stage machine, duty, relay, pwm compare
    function automatic charge_res_t charge_step(input logic [15:0] v_raw,
                                                input logic signed [15:0] i_raw);
        longint      v_l;
        longint      sample;
        longint      absv;
        longint      tgt;
        int          cur;
        int          bulk_i;
        int          max_i;
        int          delta;
        int          cmp;
        charge_res_t r;
        v_l    = longint'(v_raw);
        sample = v_l * FIX_ONE;
        cur    = int'(i_raw);
        bulk_i = int'(thresholds.bulk_current_ma);
        max_i  = int'(thresholds.max_current_ma);
        absv   = mv_fix(longint'(thresholds.absorb_voltage_mv));
        delta  = 0;

        // exponential filter, the first sample loads it
        if (!filt_primed) begin
            filt_acc    = sample;
            filt_primed = 1'b1;
        end else begin
            filt_acc = filt_acc + (sample - filt_acc) / 10;
        end

        // stage machine, fault entry overrides every other rule
        if (filt_acc > mv_fix(longint'(thresholds.max_voltage_mv)) || cur > max_i) begin
            stage_q = ST_FAULT;
        end else begin
            case (stage_q)
                ST_BULK: begin
                    if (filt_acc >= absv) stage_q = ST_ABSORB;
                end
                ST_ABSORB: begin
                    if (cur <= ABS_EXIT_MA && filt_acc >= absv) stage_q = ST_FLOAT;
                end
                ST_FLOAT: begin
                    if (filt_acc <= mv_fix(longint'(thresholds.restart_bulk_mv)))
                        stage_q = ST_BULK;
                end
                default: begin
                    if (filt_acc < absv && cur < bulk_i) stage_q = ST_BULK;
                end
            endcase
        end

        // duty stepping with deadbands, forced to zero in fault
        if (stage_q == ST_FAULT) begin
            duty_q = 0;
        end else begin
            if (stage_q == ST_BULK) begin
                if (cur < bulk_i) delta = DUTY_INC;
                else if (cur > bulk_i + CUR_DEADBAND_MA) delta = -DUTY_INC;
            end else begin
                tgt = (stage_q == ST_ABSORB) ? longint'(thresholds.absorb_voltage_mv)
                                             : longint'(thresholds.float_voltage_mv);
                if (filt_acc < mv_fix(tgt - VOLT_DEADBAND_MV)) delta = DUTY_INC;
                else if (filt_acc > mv_fix(tgt + VOLT_DEADBAND_MV)) delta = -DUTY_INC;
            end
            duty_q = duty_q + delta;
            if (duty_q > DUTY_MAX) duty_q = DUTY_MAX;
            if (duty_q < DUTY_MIN) duty_q = DUTY_MIN;
        end

        // relay hysteresis, off wins on overlap
        if (filt_acc <= mv_fix(longint'(thresholds.load_off_mv))) load_q = 1'b0;
        else if (filt_acc >= mv_fix(longint'(thresholds.load_on_mv))) load_q = 1'b1;

        cmp = duty_q * (PWM_TOP_DEF + 1) / 10000;
        if (cmp > PWM_TOP_DEF) cmp = PWM_TOP_DEF;

        r.stage = stage_q;
        r.duty  = 14'(duty_q);
        r.pwm   = 9'(cmp);
        r.load  = load_q;
        r.filt  = 16'(filt_acc / FIX_ONE);
        return r;
    endfunction

    task automatic report_field(input string fname, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            errors++;
        end
    endtask

    task automatic check_result(input charge_res_t want, input logic [47:0] got);
        report_field("charge_stage", 32'(want.stage), 32'(got[1:0]));
        report_field("duty_level", 32'(want.duty), 32'(got[15:2]));
        report_field("pwm_compare", 32'(want.pwm), 32'(got[24:16]));
        report_field("load_enable", 32'(want.load), 32'(got[25]));
        report_field("filtered_mv", 32'(want.filt), 32'(got[41:26]));
        report_field("zero fill", 32'd0, 32'(got[47:42]));
    endtask

    // request driver, fed from the pending queue
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                charge_results_due.push_back(charge_step(s_tdata[15:0], s_tdata[31:16]));
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_readings.size() > 0) begin
                    s_tdata  <= pending_readings.pop_front();
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 63) == 0) send_idle_on = !send_idle_on;
                    send_gap = send_idle_on ? $urandom_range(0, 5) : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (charge_results_due.size() == 0) begin
                    $display("%0t: result with none expected, expected nothing, actual %h",
                             $time, m_tdata);
                    errors++;
                end else begin
                    check_result(charge_results_due.pop_front(), m_tdata);
                end
                if ($urandom_range(0, 63) == 0) recv_idle_on = !recv_idle_on;
                recv_gap = recv_idle_on ? $urandom_range(0, 5) : 0;
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // apb write: setup then access, mirror keeps the low bits
    task automatic write_threshold(input logic [2:0] idx, input int value, input bit junk);
        logic [31:0] data;
        data = 32'(value);
        if (junk) data[31:16] = 16'($urandom());
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ABSORB_V:  thresholds.absorb_voltage_mv = data[15:0];
            REG_FLOAT_V:   thresholds.float_voltage_mv  = data[15:0];
            REG_RESTART_V: thresholds.restart_bulk_mv   = data[15:0];
            REG_MAX_V:     thresholds.max_voltage_mv    = data[15:0];
            REG_BULK_I:    thresholds.bulk_current_ma   = data[14:0];
            REG_MAX_I:     thresholds.max_current_ma    = data[14:0];
            REG_LOAD_OFF:  thresholds.load_off_mv       = data[15:0];
            default:       thresholds.load_on_mv        = data[15:0];
        endcase
    endtask

    task automatic program_thresholds(input int a, input int f, input int r, input int mx,
                                      input int bi, input int mi, input int off,
                                      input int on, input bit junk);
        write_threshold(REG_ABSORB_V, a, junk);
        write_threshold(REG_FLOAT_V, f, junk);
        write_threshold(REG_RESTART_V, r, junk);
        write_threshold(REG_MAX_V, mx, junk);
        write_threshold(REG_BULK_I, bi, junk);
        write_threshold(REG_MAX_I, mi, junk);
        write_threshold(REG_LOAD_OFF, off, junk);
        write_threshold(REG_LOAD_ON, on, junk);
        @(negedge aclk);
    endtask

    // plausible lead-acid settings, load thresholds may overlap
    task automatic program_plausible();
        int bi;
        bi = $urandom_range(50, 600);
        program_thresholds($urandom_range(7000, 7600), $urandom_range(6500, 7000),
                           $urandom_range(6000, 6500), $urandom_range(7400, 8200),
                           bi, bi + $urandom_range(0, 400),
                           $urandom_range(5600, 6200), $urandom_range(6000, 6700),
                           1'($urandom_range(0, 1)));
    endtask

    task automatic queue_sample(input int v, input int i);
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        if (i < -32768) i = -32768;
        if (i > 32767) i = 32767;
        pending_readings.push_back({16'(i), 16'(v)});
    endtask

    function automatic int pick_voltage();
        int spread;
        spread = int'($urandom_range(0, 240)) - 120;
        case ($urandom_range(0, 7))
            0: return int'(thresholds.absorb_voltage_mv) + spread;
            1: return int'(thresholds.float_voltage_mv) + spread;
            2: return int'(thresholds.restart_bulk_mv) + spread;
            3: return int'(thresholds.max_voltage_mv) + spread;
            4: return int'(thresholds.load_off_mv) + spread;
            5: return int'(thresholds.load_on_mv) + spread;
            6: return $urandom_range(0, 65535);
            default: return $urandom_range(0, 8000);
        endcase
    endfunction

    function automatic int pick_current();
        case ($urandom_range(0, 5))
            0: return int'(thresholds.bulk_current_ma) + int'($urandom_range(0, 300)) - 150;
            1: return ABS_EXIT_MA + int'($urandom_range(0, 100)) - 50;
            2: return int'(thresholds.max_current_ma) + int'($urandom_range(0, 120)) - 60;
            3: return int'($urandom_range(0, 1000)) - 500;
            4: return int'($urandom_range(0, 65535)) - 32768;
            default: return 0;
        endcase
    endfunction

    // runs of steady voltage and current, mostly near the thresholds, with noise and some random words
    task automatic queue_runs(input int count);
        int done_cnt;
        int run_len;
        int v_aim;
        int i_aim;
        int k;
        done_cnt = 0;
        while (done_cnt < count) begin
            if ($urandom_range(0, 7) == 0) begin
                pending_readings.push_back($urandom());
                done_cnt++;
            end else begin
                v_aim   = pick_voltage();
                i_aim   = pick_current();
                run_len = $urandom_range(5, 40);
                for (k = 0; k < run_len; k++) begin
                    queue_sample(v_aim + int'($urandom_range(0, 60)) - 30,
                                 i_aim + int'($urandom_range(0, 40)) - 20);
                end
                done_cnt += run_len;
            end
        end
    endtask

    // wait until every request is sent and every result is back
    task automatic drain();
        while (pending_readings.size() > 0 || s_tvalid || charge_results_due.size() > 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYC) @(negedge aclk);
    endtask

    initial begin
        int chunks;
        int k;
        thresholds.absorb_voltage_mv = 16'd7300;
        thresholds.float_voltage_mv  = 16'd6800;
        thresholds.restart_bulk_mv   = 16'd6300;
        thresholds.max_voltage_mv    = 16'd7500;
        thresholds.bulk_current_ma   = 15'd200;
        thresholds.max_current_ma    = 15'd400;
        thresholds.load_off_mv       = 16'd5850;
        thresholds.load_on_mv        = 16'd6450;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // default thresholds with directed samples
        program_thresholds(7300, 6800, 6300, 7500, 200, 400, 5850, 6450, 1'b0);
        queue_sample(7000, 100);      // first sample loads the filter
        queue_sample(7000, 350);      // above bulk deadband, duty down
        queue_sample(7000, 250);      // inside bulk deadband
        queue_sample(7000, 200);      // at bulk target
        queue_sample(7400, 400);      // current at limit, no fault
        queue_sample(7000, 401);      // overcurrent fault
        queue_sample(7000, 100);      // recovery, duty restarts at minimum
        queue_sample(65535, 0);       // overvoltage fault
        queue_sample(0, -32768);
        queue_sample(0, 32767);
        for (k = 0; k < 8; k++) queue_sample(0, 0);   // decay, recovery, relay off
        queue_sample(65535, -1);
        queue_sample(0, -32768);
        queue_sample(21845, 21845);
        queue_sample(43690, -21846);
        queue_runs(100);
        drain();

        // widest thresholds: nothing faults, duty climbs steadily
        program_thresholds(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535, 1'b1);
        chunks = 0;
        while (duty_q < DUTY_MAX && chunks < 12) begin
            queue_runs(50);
            drain();
            chunks++;
        end
        queue_runs(20);
        drain();

        // all thresholds zero
        program_thresholds(0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        queue_runs(60);
        drain();

        program_plausible();
        queue_runs(80);
        drain();

        // overlapping relay thresholds
        program_thresholds(7200, 6700, 6200, 7600, 300, 600, 6600, 6100, 1'b1);
        queue_runs(80);
        drain();

        program_plausible();
        queue_runs(80);
        drain();

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
